/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the header parser RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");

`endif

/* hw/rtl/pnmhp_pkg.sv */
// Shared types and constants for the netpbm header parser.
// No dependencies; imported by every module of the block.
package pnmhp_pkg;

	typedef enum logic [1:0] {
		ST_MORE    = 2'd0,
		ST_ACCEPT  = 2'd1,
		ST_REJECT  = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] image_height;
		logic [15:0] image_width;
		status_t     status;
	} result_t;

	localparam int CFG_INDEX_BITS = 4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MAGIC_FIRST  = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MAGIC_SECOND = 4'd1;

	localparam logic [7:0] MAGIC_FIRST_RESET  = 8'h50;
	localparam logic [7:0] MAGIC_SECOND_RESET = 8'h36;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int MAXVAL = 255;

endpackage

/* hw/rtl/pnmhp_core.sv */
// Parser state and the single-step next-state and result logic.
// Depends on pnmhp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pnmhp_core
	import pnmhp_pkg::*;
#(
	parameter int DIM_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic       kind,
	input  logic       start_req,
	input  logic [7:0] byte_value,
	input  logic [7:0] magic_first,
	input  logic [7:0] magic_second,
	output result_t    res
);

	typedef enum logic [2:0] {
		PH_MAGIC1,
		PH_MAGIC2,
		PH_NUMBERS,
		PH_COMMENT,
		PH_DONE
	} phase_t;

	localparam int ACC_W = DIM_BITS + 4;
	localparam logic [DIM_BITS-1:0] LIMIT = '1;

	phase_t              phase_q, cur_phase, nxt_phase;
	logic [1:0]          vidx_q, cur_vidx, nxt_vidx;
	logic                digits_q, cur_digits, nxt_digits;
	logic                sat_q, cur_sat, nxt_sat;
	logic [DIM_BITS-1:0] acc_q   [3];
	logic [DIM_BITS-1:0] cur_acc [3];
	logic [DIM_BITS-1:0] nxt_acc [3];
	logic [DIM_BITS-1:0] acc_sel, acc_new;
	logic [ACC_W-1:0]    acc_ext, prod;
	logic                ovf, is_digit, is_ws, hdr_ok;
	logic [DIM_BITS+15:0] width_ext, height_ext;
	status_t             status;

	always_comb begin
		// A restart request works on cleared state.
		cur_phase  = start_req ? PH_MAGIC1 : phase_q;
		cur_vidx   = start_req ? 2'd0 : vidx_q;
		cur_digits = start_req ? 1'b0 : digits_q;
		cur_sat    = start_req ? 1'b0 : sat_q;
		for (int i = 0; i < 3; i++) begin
			cur_acc[i] = start_req ? '0 : acc_q[i];
		end

		case (cur_vidx)
			2'd0:    acc_sel = cur_acc[0];
			2'd1:    acc_sel = cur_acc[1];
			2'd2:    acc_sel = cur_acc[2];
			default: acc_sel = '0;
		endcase

		// Times ten as two shifts; ASCII digits carry their value in the low nibble.
		acc_ext = {4'b0, acc_sel};
		prod    = (acc_ext << 3) + (acc_ext << 1) + {{DIM_BITS{1'b0}}, byte_value[3:0]};
		ovf     = prod > {4'b0, LIMIT};
		acc_new = ovf ? LIMIT : prod[DIM_BITS-1:0];

		is_digit = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
		is_ws    = (byte_value == CH_SPACE) || (byte_value == CH_TAB) ||
			(byte_value == CH_CR) || (byte_value == CH_LF);
		hdr_ok   = (cur_acc[0] != '0) && (cur_acc[1] != '0) &&
			(cur_acc[2] == DIM_BITS'(MAXVAL)) && !cur_sat;

		nxt_phase  = cur_phase;
		nxt_vidx   = cur_vidx;
		nxt_digits = cur_digits;
		nxt_sat    = cur_sat;
		for (int i = 0; i < 3; i++) begin
			nxt_acc[i] = cur_acc[i];
		end
		status = ST_MORE;

		if (cur_phase == PH_DONE) begin
			status = ST_IGNORED;
		end else if (kind) begin
			status = ST_REJECT;
		end else begin
			case (cur_phase)
				PH_MAGIC1: begin
					if (byte_value == magic_first) nxt_phase = PH_MAGIC2;
					else status = ST_REJECT;
				end
				PH_MAGIC2: begin
					if (byte_value == magic_second) nxt_phase = PH_NUMBERS;
					else status = ST_REJECT;
				end
				PH_COMMENT: begin
					if (byte_value == CH_LF) nxt_phase = PH_NUMBERS;
				end
				PH_NUMBERS: begin
					if (byte_value == CH_HASH) begin
						nxt_phase = PH_COMMENT;
					end else if (is_digit) begin
						case (cur_vidx)
							2'd0:    nxt_acc[0] = acc_new;
							2'd1:    nxt_acc[1] = acc_new;
							2'd2:    nxt_acc[2] = acc_new;
							default: ;
						endcase
						nxt_sat    = cur_sat | ovf;
						nxt_digits = 1'b1;
					end else if (is_ws) begin
						if (cur_digits) begin
							nxt_digits = 1'b0;
							nxt_vidx   = cur_vidx + 2'd1;
							if (cur_vidx == 2'd2) status = hdr_ok ? ST_ACCEPT : ST_REJECT;
						end
					end else begin
						status = ST_REJECT;
					end
				end
				default: status = ST_REJECT;
			endcase
		end

		if (status == ST_ACCEPT || status == ST_REJECT) nxt_phase = PH_DONE;

		width_ext  = {16'b0, cur_acc[0]};
		height_ext = {16'b0, cur_acc[1]};
		res.status = status;
		res.image_width  = (status == ST_ACCEPT) ? width_ext[15:0] : 16'b0;
		res.image_height = (status == ST_ACCEPT) ? height_ext[15:0] : 16'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC1;
			vidx_q   <= 2'd0;
			digits_q <= 1'b0;
			sat_q    <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
			end
		end else if (fire) begin
			phase_q  <= nxt_phase;
			vidx_q   <= nxt_vidx;
			digits_q <= nxt_digits;
			sat_q    <= nxt_sat;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= nxt_acc[i];
			end
		end
	end

	`ASSERT_IMPLIES(a_index_bound, clk, arst_n, phase_q != PH_DONE, vidx_q != 2'd3)
	`ASSERT_IMPLIES(a_no_digits_in_magic, clk, arst_n, phase_q == PH_MAGIC1 || phase_q == PH_MAGIC2, !digits_q)

endmodule

/* hw/rtl/pnmhp_out_reg.sv */
// Result register between the parse step and the output stream.
// Depends on pnmhp_pkg.
module pnmhp_out_reg
	import pnmhp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	input  logic    out_ready,
	output logic    in_ready,
	output logic    out_valid,
	output result_t res_q
);

	logic valid_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= res_in;
	end

endmodule

/* hw/rtl/pnm_header_parser.sv */
// Top level of the streaming netpbm header parser.
// Depends on pnmhp_pkg, pnmhp_core, pnmhp_out_reg and assert_macros.svh.
`include "assert_macros.svh"

// The parser takes one stream byte (or an end-of-stream mark) per transfer and
// returns exactly one result per input transfer, in the cycle after it is taken.
// It takes one transfer per clock unless stalled: the whole parse step, a compare
// of the byte against the magic and separator codes plus a times-ten accumulate,
// runs from the parser state registers straight into the result register. The
// input is ready whenever the result register is empty or is being drained in
// the same cycle. Status reads 0 while more bytes are needed, 1 when the header
// is accepted (width and height then valid), 2 when it is rejected and 3 for
// bytes that arrive after the header finished; a transfer with start_req set
// begins a new header with that byte as the first magic byte. The two magic
// bytes are set through the configuration channel, which should be written
// only while no transfer is in flight; indexes other than 0 and 1 are ignored.
module pnm_header_parser
	import pnmhp_pkg::*;
#(
	parameter int DIM_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [7:0]                s_axis_tdata,  // byte_value
	input  logic [1:0]                s_axis_tuser,  // kind, start_req
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [31:0]               m_axis_tdata,  // image_width, image_height
	output logic [1:0]                m_axis_tuser,  // status
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [7:0]                cfg_data
);

	logic       in_fire;
	logic [7:0] magic_first_q, magic_second_q;
	result_t    step_res, out_res;

	// Configuration is always taken; the registers only matter in the magic phases.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q  <= MAGIC_FIRST_RESET;
			magic_second_q <= MAGIC_SECOND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MAGIC_FIRST) magic_first_q <= cfg_data;
			if (cfg_index == CFG_MAGIC_SECOND) magic_second_q <= cfg_data;
		end
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	// Parser state only moves on an accepted input transfer.
	pnmhp_core #(
		.DIM_BITS(DIM_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (in_fire),
		.kind        (s_axis_tuser[0]),
		.start_req   (s_axis_tuser[1]),
		.byte_value  (s_axis_tdata),
		.magic_first (magic_first_q),
		.magic_second(magic_second_q),
		.res         (step_res)
	);

	pnmhp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (in_fire),
		.res_in   (step_res),
		.out_ready(m_axis_tready),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.res_q    (out_res)
	);

	assign m_axis_tdata = {out_res.image_height, out_res.image_width};
	assign m_axis_tuser = out_res.status;

	// Every accepted byte must show up as a result in the following cycle.
	`ASSERT_NEXT(a_fire_gives_result, clk, arst_n, in_fire, m_axis_tvalid)
	// Dimensions are only reported with an accepted header.
	`ASSERT_IMPLIES(a_dims_only_on_accept, clk, arst_n, m_axis_tvalid && (m_axis_tuser != ST_ACCEPT), m_axis_tdata == 32'b0)

endmodule
